@@ rtl/ndopt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndopt_pkg: shared definitions of the neighbor-discovery option parser
// Option type codes, result status codes, the per-byte command that the
// front end hands to the back end, and the command queue depth.
// ----------------------------------------------------------------------------
package ndopt_pkg;

   // Number of link-layer address bytes captured for types 1 and 2 (6..8)
   localparam int ADDR_CAPTURE_BYTES = 8;

   // Depth of the command queue between front and back end
   localparam int CMD_FIFO_DEPTH = 4;

   // Option type codes
   localparam logic [7:0] OPT_SRC_LINK_ADDR = 8'd1;
   localparam logic [7:0] OPT_TGT_LINK_ADDR = 8'd2;
   localparam logic [7:0] OPT_PREFIX_INFO   = 8'd3;
   localparam logic [7:0] OPT_MTU           = 8'd5;

   // Option sizes that allow a full decode
   localparam logic [10:0] PREFIX_INFO_BYTES = 11'd30;
   localparam logic [10:0] MTU_BODY_BYTES    = 11'd6;

   // Prefix flag bit positions in the flags byte
   localparam int FLAG_ON_LINK_BIT = 7;
   localparam int FLAG_AUTO_BIT    = 6;

   // Result status codes
   localparam logic [2:0] STATUS_DECODED   = 3'd0;
   localparam logic [2:0] STATUS_RAW       = 3'd1;
   localparam logic [2:0] STATUS_ZERO_LEN  = 3'd2;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd3;
   localparam logic [2:0] STATUS_END_ONLY  = 3'd4;

   // What the back end does with the byte of a command
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_CLEAR,
      ACT_PREFIX_LEN,
      ACT_FLAGS,
      ACT_LIFE_VALID,
      ACT_LIFE_PREF,
      ACT_SHIFT_HIGH,
      ACT_SHIFT_LOW
   } act_type;

   // Which decoded fields a result carries
   typedef enum logic [1:0] {
      SHOW_NONE,
      SHOW_LINK,
      SHOW_PREFIX,
      SHOW_MTU
   } show_type;

   // One classified byte, from front end to back end
   typedef struct packed {
      logic [7:0]  data;
      act_type     act;
      logic        emit;
      logic [2:0]  status;
      logic        end_flag;
      logic [7:0]  opt_type;
      logic [7:0]  opt_units;
      logic [10:0] pay_len;
      show_type    show;
   } cmd_type;

endpackage

@@ rtl/ndopt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndopt_front: option framing and byte classification
// Tracks type, length and body position of the current option and turns
// each accepted byte into a command for the back end.
// ----------------------------------------------------------------------------
module ndopt_front import ndopt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        fifo_full,
   output logic        cmd_push,
   output cmd_type     cmd
);

   typedef enum logic [3:0] {
      PH_TYPE = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_BODY = 4'b0100,
      PH_STOP = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  units_ff, units_in;
   logic [10:0] count_ff, count_in;

   logic        accept;
   logic [10:0] body_len;
   logic [10:0] count_next;
   logic        is_link;
   logic        dec_link, dec_prefix, dec_mtu, dec_any;
   act_type     body_act;

   assign req_ready = !fifo_full;
   assign accept    = req_valid && req_ready;
   assign cmd_push  = accept;

   // Body length in bytes and the count after this byte
   assign body_len   = {units_ff, 3'b000} - 11'd2;
   assign count_next = count_ff + 11'd1;

   assign is_link    = (type_ff == OPT_SRC_LINK_ADDR) || (type_ff == OPT_TGT_LINK_ADDR);
   assign dec_link   = is_link && (count_next == body_len);
   assign dec_prefix = (type_ff == OPT_PREFIX_INFO) && (count_next >= PREFIX_INFO_BYTES);
   assign dec_mtu    = (type_ff == OPT_MTU) && (count_next >= MTU_BODY_BYTES);
   assign dec_any    = dec_link || dec_prefix || dec_mtu;

   // Pick the field that a body byte feeds, by type and offset
   always_comb begin
      body_act = ACT_NONE;
      if (type_ff == OPT_PREFIX_INFO) begin
         if (count_ff == 11'd0) begin
            body_act = ACT_PREFIX_LEN;
         end else if (count_ff == 11'd1) begin
            body_act = ACT_FLAGS;
         end else if (count_ff >= 11'd2 && count_ff <= 11'd5) begin
            body_act = ACT_LIFE_VALID;
         end else if (count_ff >= 11'd6 && count_ff <= 11'd9) begin
            body_act = ACT_LIFE_PREF;
         end else if (count_ff >= 11'd14 && count_ff <= 11'd21) begin
            body_act = ACT_SHIFT_HIGH;
         end else if (count_ff >= 11'd22 && count_ff <= 11'd29) begin
            body_act = ACT_SHIFT_LOW;
         end
      end else if (type_ff == OPT_MTU) begin
         if (count_ff >= 11'd2 && count_ff <= 11'd5) begin
            body_act = ACT_SHIFT_LOW;
         end
      end else if (is_link) begin
         if (count_ff < 11'(ADDR_CAPTURE_BYTES)) begin
            body_act = ACT_SHIFT_HIGH;
         end
      end
   end

   // Advance the framing state and build the command
   always_comb begin
      phase_in      = phase_ff;
      type_in       = type_ff;
      units_in      = units_ff;
      count_in      = count_ff;
      cmd           = '0;
      cmd.data      = req_data_byte;
      cmd.act       = ACT_NONE;
      cmd.show      = SHOW_NONE;
      cmd.end_flag  = req_last;
      case (phase_ff)
         PH_TYPE: begin
            type_in = req_data_byte;
            if (req_last) begin
               cmd.emit     = 1'b1;
               cmd.status   = STATUS_TRUNCATED;
               cmd.opt_type = req_data_byte;
               phase_in     = PH_TYPE;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            units_in = req_data_byte;
            count_in = '0;
            cmd.act  = ACT_CLEAR;
            if (req_data_byte == 8'd0) begin
               cmd.emit     = 1'b1;
               cmd.status   = STATUS_ZERO_LEN;
               cmd.opt_type = type_ff;
               phase_in     = req_last ? PH_TYPE : PH_STOP;
            end else if (req_last) begin
               cmd.emit      = 1'b1;
               cmd.status    = STATUS_RAW;
               cmd.opt_type  = type_ff;
               cmd.opt_units = req_data_byte;
               phase_in      = PH_TYPE;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            count_in = count_next;
            cmd.act  = body_act;
            if (req_last || (count_next == body_len)) begin
               cmd.emit      = 1'b1;
               cmd.opt_type  = type_ff;
               cmd.opt_units = units_ff;
               phase_in      = PH_TYPE;
               if (dec_any) begin
                  cmd.status = STATUS_DECODED;
                  if (dec_prefix) begin
                     cmd.show = SHOW_PREFIX;
                  end else if (dec_mtu) begin
                     cmd.show = SHOW_MTU;
                  end else begin
                     cmd.show = SHOW_LINK;
                  end
               end else begin
                  cmd.status  = STATUS_RAW;
                  cmd.pay_len = count_next;
               end
            end
         end
         PH_STOP: begin
            if (req_last) begin
               cmd.emit   = 1'b1;
               cmd.status = STATUS_END_ONLY;
               phase_in   = PH_TYPE;
            end
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase
   end

   // Hold state between transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         type_ff  <= '0;
         units_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         units_ff <= units_in;
         count_ff <= count_in;
      end
   end

   // The last byte of the area always restarts parsing at a type byte
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (phase_ff == PH_TYPE))
      else $error("parsing did not restart after the last byte");

endmodule

@@ rtl/ndopt_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndopt_fifo: command queue between front and back end
// A few entries of classified bytes so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ndopt_fifo import ndopt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    not_empty
);

   localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_FIFO_DEPTH - 1);

   cmd_type           entry_ff [CMD_FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(CMD_FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("command queue underflow");

endmodule

@@ rtl/ndopt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndopt_back: field assembly and result register
// Applies each command to the decode registers and loads the result
// register when a command finishes an option.
// ----------------------------------------------------------------------------
module ndopt_back import ndopt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_option_type,
   output logic [7:0]  rsp_option_units,
   output logic [7:0]  rsp_prefix_length,
   output logic [1:0]  rsp_prefix_flags,
   output logic [31:0] rsp_valid_lifetime,
   output logic [31:0] rsp_preferred_lifetime,
   output logic [63:0] rsp_word_high,
   output logic [63:0] rsp_word_low,
   output logic [10:0] rsp_payload_length,
   output logic        rsp_end_of_area
);

   logic [63:0] high_ff, high_in;
   logic [63:0] low_ff, low_in;
   logic [31:0] life_v_ff, life_v_in;
   logic [31:0] life_p_ff, life_p_in;
   logic [7:0]  plen_ff, plen_in;
   logic [1:0]  flags_ff, flags_in;

   logic        rsp_valid_ff;
   logic [2:0]  status_ff;
   logic [7:0]  opt_type_ff, opt_units_ff, plen_out_ff;
   logic [1:0]  flags_out_ff;
   logic [31:0] life_v_out_ff, life_p_out_ff;
   logic [63:0] high_out_ff, low_out_ff;
   logic [10:0] pay_len_ff;
   logic        end_ff;

   logic        load;

   // Drain non-result commands freely; result commands need a free register
   assign cmd_pop = cmd_valid && (!cmd.emit || !rsp_valid_ff || rsp_ready);
   assign load    = cmd_pop && cmd.emit;

   // Apply the command byte to the decode registers
   always_comb begin
      high_in   = high_ff;
      low_in    = low_ff;
      life_v_in = life_v_ff;
      life_p_in = life_p_ff;
      plen_in   = plen_ff;
      flags_in  = flags_ff;
      case (cmd.act)
         ACT_NONE: begin
         end
         ACT_CLEAR: begin
            high_in   = '0;
            low_in    = '0;
            life_v_in = '0;
            life_p_in = '0;
            plen_in   = '0;
            flags_in  = '0;
         end
         ACT_PREFIX_LEN: plen_in = cmd.data;
         ACT_FLAGS: begin
            flags_in = {cmd.data[FLAG_ON_LINK_BIT], cmd.data[FLAG_AUTO_BIT]};
         end
         ACT_LIFE_VALID: life_v_in = {life_v_ff[23:0], cmd.data};
         ACT_LIFE_PREF:  life_p_in = {life_p_ff[23:0], cmd.data};
         ACT_SHIFT_HIGH: high_in   = {high_ff[55:0], cmd.data};
         ACT_SHIFT_LOW:  low_in    = {low_ff[55:0], cmd.data};
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         high_ff   <= high_in;
         low_ff    <= low_in;
         life_v_ff <= life_v_in;
         life_p_ff <= life_p_in;
         plen_ff   <= plen_in;
         flags_ff  <= flags_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the result payload, with fields that the status does not use at zero
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff     <= cmd.status;
         opt_type_ff   <= cmd.opt_type;
         opt_units_ff  <= cmd.opt_units;
         pay_len_ff    <= cmd.pay_len;
         end_ff        <= cmd.end_flag;
         plen_out_ff   <= '0;
         flags_out_ff  <= '0;
         life_v_out_ff <= '0;
         life_p_out_ff <= '0;
         high_out_ff   <= '0;
         low_out_ff    <= '0;
         case (cmd.show)
            SHOW_NONE: begin
            end
            SHOW_LINK: high_out_ff <= high_in;
            SHOW_PREFIX: begin
               plen_out_ff   <= plen_in;
               flags_out_ff  <= flags_in;
               life_v_out_ff <= life_v_in;
               life_p_out_ff <= life_p_in;
               high_out_ff   <= high_in;
               low_out_ff    <= low_in;
            end
            SHOW_MTU: low_out_ff <= {32'd0, low_in[31:0]};
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_option_type        = opt_type_ff;
   assign rsp_option_units       = opt_units_ff;
   assign rsp_prefix_length      = plen_out_ff;
   assign rsp_prefix_flags       = flags_out_ff;
   assign rsp_valid_lifetime     = life_v_out_ff;
   assign rsp_preferred_lifetime = life_p_out_ff;
   assign rsp_word_high          = high_out_ff;
   assign rsp_word_low           = low_out_ff;
   assign rsp_payload_length     = pay_len_ff;
   assign rsp_end_of_area        = end_ff;

   // A stalled result is never overwritten by a new one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && cmd_pop) |-> !cmd.emit)
      else $error("pending result overwritten");

   // Decoded fields go out only with a decoded status
   a_show_decoded: assert property (@(posedge clock) disable iff (reset)
      (load && (cmd.show != SHOW_NONE)) |-> (cmd.status == STATUS_DECODED))
      else $error("decoded fields on a non-decoded result");

endmodule

@@ rtl/nd_option_tlv_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nd_option_tlv_parser_core: ICMPv6 neighbor-discovery option parser
// Byte-wide parser of the options area with one result per finished option.
// ----------------------------------------------------------------------------
// The block takes one byte of the options area per cycle while the command
// queue is not full, and gives at most one result per byte. An accepted byte
// is classified by the framing front end into a four-entry command queue; the
// back end pops it, applies it to the field registers and, where it finishes
// an option, loads the result register, which then goes valid. The rate is
// set by the framing update of the front end; while the result register
// waits on rsp_ready, bytes that finish no option keep draining, and
// req_ready drops only once the command queue is full.
// Prefix information is decoded only when all 30 of its bytes arrive;
// types 1 and 2 give the first eight link-address bytes, type 5 the MTU.
// ----------------------------------------------------------------------------
module nd_option_tlv_parser_core import ndopt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_option_type,
   output logic [7:0]  rsp_option_units,
   output logic [7:0]  rsp_prefix_length,
   output logic [1:0]  rsp_prefix_flags,
   output logic [31:0] rsp_valid_lifetime,
   output logic [31:0] rsp_preferred_lifetime,
   output logic [63:0] rsp_word_high,
   output logic [63:0] rsp_word_low,
   output logic [10:0] rsp_payload_length,
   output logic        rsp_end_of_area
);

   cmd_type push_cmd, pop_cmd;
   logic    push, pop, full, not_empty;

   // Frame and classify incoming bytes
   ndopt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .fifo_full     (full),
      .cmd_push      (push),
      .cmd           (push_cmd)
   );

   // Decouple front and back end
   ndopt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .pop_cmd   (pop_cmd),
      .not_empty (not_empty)
   );

   // Assemble fields and deliver results
   ndopt_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cmd_valid              (not_empty),
      .cmd                    (pop_cmd),
      .cmd_pop                (pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_option_type        (rsp_option_type),
      .rsp_option_units       (rsp_option_units),
      .rsp_prefix_length      (rsp_prefix_length),
      .rsp_prefix_flags       (rsp_prefix_flags),
      .rsp_valid_lifetime     (rsp_valid_lifetime),
      .rsp_preferred_lifetime (rsp_preferred_lifetime),
      .rsp_word_high          (rsp_word_high),
      .rsp_word_low           (rsp_word_low),
      .rsp_payload_length     (rsp_payload_length),
      .rsp_end_of_area        (rsp_end_of_area)
   );

endmodule
